// ----- design/rtip_pkg.sv -----
package rtip_pkg;

  localparam int COUNT_BITS_DEF = 8;

  localparam int RADIX_W   = 6;
  localparam int ACCUM_W   = 64;
  localparam int PHASE_W   = 3;
  localparam int CHAR_W    = 8;
  localparam int CONSUMED_W = 8;

  localparam logic [PHASE_W-1:0] PH_WS     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd3;

  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               minus_seen;
    logic [ACCUM_W-1:0] accum;
    logic [RADIX_W-1:0] active_radix;
  } parse_state_t;

  typedef struct packed {
    logic               ok;
    logic [RADIX_W-1:0] val;
  } digit_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:        PH_WS,
    minus_seen:   1'b0,
    accum:        '0,
    active_radix: '0
  };

  // Maps '0'-'9', 'a'-'z' and 'A'-'Z' to 0..35.
  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    logic [CHAR_W-1:0] t;
    d.ok = 1'b0;
    t    = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok = 1'b1;
      t    = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d.ok = 1'b1;
      t    = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d.ok = 1'b1;
      t    = c - CH_UA + 8'd10;
    end
    d.val = t[RADIX_W-1:0];
    return d;
  endfunction

endpackage

// ----- design/rtip_step.sv -----
module rtip_step
  import rtip_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  parse_state_t          st,
  input  logic [COUNT_BITS-1:0] cnt,
  input  logic [CHAR_W-1:0]     ch,
  input  logic [RADIX_W-1:0]    radix,
  output parse_state_t          st_next,
  output logic [COUNT_BITS-1:0] cnt_next,
  output logic                  emit,
  output logic [ACCUM_W-1:0]    res_value
);

  logic                  is_space;
  logic                  is_sign;
  logic                  first_zero;
  logic [RADIX_W-1:0]    first_radix;
  logic [RADIX_W-1:0]    use_radix;
  logic                  digit_path;
  digit_t                dig;
  logic                  dig_ok;
  logic [ACCUM_W+RADIX_W-1:0] prod;
  logic [ACCUM_W-1:0]    mac;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign is_space   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
  assign is_sign    = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign first_zero = (ch == CH_ZERO) && ((radix == RADIX_AUTO) || (radix == RADIX_HEX));
  assign first_radix = (radix == RADIX_AUTO) ? RADIX_DEC : radix;

  // The first character after whitespace and sign samples the radix register;
  // later digits use the radix latched then.
  assign digit_path = (st.phase == PH_WS) || (st.phase == PH_SIGN);
  assign use_radix  = digit_path ? first_radix : st.active_radix;

  assign dig    = digit_of(ch);
  assign dig_ok = dig.ok && (dig.val < use_radix);
  assign prod   = {{RADIX_W{1'b0}}, st.accum} * {{ACCUM_W{1'b0}}, use_radix};
  assign mac    = prod[ACCUM_W-1:0] + {{(ACCUM_W-RADIX_W){1'b0}}, dig.val};

  assign cnt_inc   = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + 1'b1;
  assign res_value = st.minus_seen ? (~st.accum + 64'd1) : st.accum;

  always_comb begin
    st_next  = st;
    cnt_next = cnt;
    emit     = 1'b0;
    unique case (st.phase)
      PH_WS, PH_SIGN: begin
        if (st.phase == PH_WS && is_space) begin
          cnt_next = cnt_inc;
        end else if (st.phase == PH_WS && is_sign) begin
          st_next.minus_seen = (ch == CH_MINUS);
          st_next.phase      = PH_SIGN;
          cnt_next           = cnt_inc;
        end else if (first_zero) begin
          st_next.active_radix = (radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
          st_next.accum        = '0;
          st_next.phase        = PH_ZERO;
          cnt_next             = cnt_inc;
        end else if (dig_ok) begin
          st_next.active_radix = first_radix;
          st_next.accum        = mac;
          st_next.phase        = PH_DIGITS;
          cnt_next             = cnt_inc;
        end else begin
          emit     = 1'b1;
          st_next  = PARSE_CLEAR;
          cnt_next = '0;
        end
      end
      PH_ZERO, PH_DIGITS: begin
        if (st.phase == PH_ZERO && (ch == CH_LX || ch == CH_UX)) begin
          st_next.active_radix = RADIX_HEX;
          st_next.phase        = PH_DIGITS;
          cnt_next             = cnt_inc;
        end else if (dig_ok) begin
          st_next.accum = mac;
          st_next.phase = PH_DIGITS;
          cnt_next      = cnt_inc;
        end else begin
          emit     = 1'b1;
          st_next  = PARSE_CLEAR;
          cnt_next = '0;
        end
      end
      default: begin
        st_next  = PARSE_CLEAR;
        cnt_next = '0;
      end
    endcase
  end

endmodule

// ----- design/radix_integer_text_parser_core.sv -----
// A character is first captured in the input register, then parsed; a result goes to
// the output register once it has room. One character per cycle is taken unless the
// output stalls; the multiply-accumulate of the value by the radix is combinational.
// Reset (synchronous): parser returns to the leading whitespace phase with value and
// count cleared, both register stages empty, and the radix register set to 10.
module radix_integer_text_parser_core
  import rtip_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RADIX_W-1:0]    cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     ch,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACCUM_W-1:0]    value,
  output logic [CONSUMED_W-1:0] consumed
);

  logic [RADIX_W-1:0]    radix;
  logic                  in_full;
  logic [CHAR_W-1:0]     ch_q;
  parse_state_t          st;
  parse_state_t          st_next;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_next;
  logic                  emit;
  logic [ACCUM_W-1:0]    res_value;
  logic                  process;
  logic [COUNT_BITS+CONSUMED_W-1:0] cnt_ext;

  // The held character is parsed only when the result register has room for it.
  assign process  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || process;
  assign cnt_ext  = {{CONSUMED_W{1'b0}}, cnt};

  rtip_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .st       (st),
    .cnt      (cnt),
    .ch       (ch_q),
    .radix    (radix),
    .st_next  (st_next),
    .cnt_next (cnt_next),
    .emit     (emit),
    .res_value(res_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RESET;
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      st        <= PARSE_CLEAR;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (process) begin
        st        <= st_next;
        cnt       <= cnt_next;
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q <= ch;
    end
    if (process && emit) begin
      value    <= res_value;
      consumed <= cnt_ext[CONSUMED_W-1:0];
    end
  end

endmodule

// ----- tb/sv/tb_radix_integer_text_parser_core.sv -----
module tb_radix_integer_text_parser_core;
  import rtip_pkg::*;

  localparam logic [6:0]         NO_DIGIT    = 7'h7F;
  localparam logic [7:0]         COUNT_SAT   = 8'hFF;
  localparam logic [RADIX_W-1:0] RADIX_UNARY = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_ALNUM = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_ODD   = 6'd37;
  localparam logic [RADIX_W-1:0] RADIX_TOP   = 6'd63;
  localparam logic [CHAR_W-1:0]  CH_FLUSH    = 8'h21;
  localparam logic [CHAR_W-1:0]  CH_SEMI     = 8'h3B;
  localparam logic [CHAR_W-1:0]  CH_COMMA    = 8'h2C;
  localparam int NUM_ROWS     = 8;
  localparam int RANDOM_CHARS = 2000;
  localparam int PHASE_CHARS  = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [RADIX_W-1:0]    radix;
    logic [3:0]            len;
    logic [63:0]           txt;
    logic                  known;
    logic [ACCUM_W-1:0]    value;
    logic [CONSUMED_W-1:0] consumed;
  } dir_row_t;

  typedef struct packed {
    logic [ACCUM_W-1:0]    value;
    logic [CONSUMED_W-1:0] consumed;
  } number_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [RADIX_W-1:0]    cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAR_W-1:0]     ch;
  logic                  out_valid;
  logic                  out_ready;
  logic [ACCUM_W-1:0]    value;
  logic [CONSUMED_W-1:0] consumed;

  // Software copy of the parser state.
  logic [PHASE_W-1:0] parse_phase;
  logic               parse_minus;
  logic [ACCUM_W-1:0] parse_accum;
  logic [7:0]         parse_count;
  logic [RADIX_W-1:0] parse_base;
  logic [RADIX_W-1:0] radix_reg;

  number_t  parsed_numbers[$];
  number_t  typed_number;
  bit       typed_pending;
  dir_row_t dir_rows[NUM_ROWS];
  int       errors;
  int       burst_left;
  int       chars_sent;
  bit       hold_req;

  radix_integer_text_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .consumed  (consumed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [6:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41 + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic void clear_number();
    parse_phase = PH_WS;
    parse_minus = 1'b0;
    parse_accum = '0;
    parse_count = '0;
    parse_base  = '0;
  endfunction

  function automatic void count_char();
    if (parse_count != COUNT_SAT) parse_count++;
  endfunction

  // Advances the parser by one character; returns 1 when a number is finished.
  function automatic bit parse_char(input logic [7:0] c, output number_t num);
    logic [6:0] d;
    num = '0;
    if (parse_phase == PH_WS && (c == CH_SPACE || c == CH_TAB || c == CH_NL)) begin
      count_char();
      return 1'b0;
    end
    if (parse_phase == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
      parse_minus = (c == CH_MINUS);
      count_char();
      parse_phase = PH_SIGN;
      return 1'b0;
    end
    if (parse_phase == PH_WS || parse_phase == PH_SIGN) begin
      // The radix register is sampled on the first character of the number body.
      if (c == CH_ZERO && (radix_reg == RADIX_AUTO || radix_reg == RADIX_HEX)) begin
        parse_base  = (radix_reg == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
        parse_accum = '0;
        count_char();
        parse_phase = PH_ZERO;
        return 1'b0;
      end
      parse_base = (radix_reg == RADIX_AUTO) ? RADIX_DEC : radix_reg;
    end else if (parse_phase == PH_ZERO && (c == CH_LX || c == CH_UX)) begin
      parse_base = RADIX_HEX;
      count_char();
      parse_phase = PH_DIGITS;
      return 1'b0;
    end
    d = digit_value(c);
    if (d != NO_DIGIT && d < {1'b0, parse_base}) begin
      parse_accum = parse_accum * {58'd0, parse_base} + {57'd0, d};
      count_char();
      parse_phase = PH_DIGITS;
      return 1'b0;
    end
    num.value    = parse_minus ? (64'd0 - parse_accum) : parse_accum;
    num.consumed = parse_count;
    clear_number();
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] c);
    number_t num;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    ch       <= c;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    chars_sent++;
    if (parse_char(c, num)) begin
      if (typed_pending) begin
        num           = typed_number;
        typed_pending = 1'b0;
      end
      parsed_numbers.push_back(num);
    end
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (parsed_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_reg = r;
  endtask

  // One number with random content, shaped to reach the digit phase most of the time.
  task automatic gen_number(input logic [RADIX_W-1:0] r);
    int         kind;
    int         nws;
    int         ndig;
    int         span;
    int         d;
    int         k;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) send_char(8'($urandom));
      return;
    end
    if ($urandom_range(0, 59) == 0) nws = $urandom_range(260, 300);
    else if ($urandom_range(0, 9) < 6) nws = 0;
    else nws = $urandom_range(1, 3);
    for (k = 0; k < nws; k++) begin
      case ($urandom_range(0, 2))
        0: send_char(CH_SPACE);
        1: send_char(CH_TAB);
        default: send_char(CH_NL);
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1: send_char(CH_PLUS);
      2, 3: send_char(CH_MINUS);
      4: begin
        if (kind == 1) begin
          send_char(CH_MINUS);
          send_char(CH_PLUS);
        end
      end
      default: ;
    endcase
    if (r == RADIX_AUTO || r == RADIX_HEX) begin
      case ($urandom_range(0, 2))
        0: begin
          send_char(CH_ZERO);
          send_char($urandom_range(0, 1) ? CH_LX : CH_UX);
        end
        1: send_char(CH_ZERO);
        default: ;
      endcase
    end
    ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 20);
    if (r == RADIX_AUTO) span = 16;
    else if (r > RADIX_ALNUM) span = 36;
    else if (r < RADIX_BIN) span = 1;
    else span = r;
    for (k = 0; k < ndig; k++) begin
      d = $urandom_range(0, span - 1);
      if (d < 10) c = 8'(8'h30 + d);
      else if ($urandom_range(0, 1) == 0) c = 8'(8'h61 + d - 10);
      else c = 8'(8'h41 + d - 10);
      send_char(c);
    end
    case ($urandom_range(0, 11))
      0: send_char(CH_SPACE);
      1: send_char(CH_SEMI);
      2: send_char(CH_COMMA);
      3: send_char(CH_NL);
      4: send_char(8'h00);
      5: send_char(8'hFF);
      default: send_char(8'($urandom));
    endcase
  endtask

  initial begin
    int k;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int mode;
      int span;
      logic [7:0] mask;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      mask = 8'($urandom);
      for (k = 0; k < span && !hold_req; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= mask[k % 8];
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Results are compared on the falling edge before the rising edge that accepts them.
  initial begin
    number_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && out_ready) begin
        if (parsed_numbers.size() == 0) begin
          report_mismatch("number with none pending", value, 64'd0);
        end else begin
          want = parsed_numbers.pop_front();
          if (value !== want.value) report_mismatch("value", value, want.value);
          if (consumed !== want.consumed)
            report_mismatch("consumed", {56'd0, consumed}, {56'd0, want.consumed});
        end
      end
    end
  end

  initial begin
    int         r;
    int         i;
    int         phase_no;
    int         phase_start;
    dir_row_t   row;
    logic [7:0] c;
    logic [RADIX_W-1:0] rad;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    ch            <= '0;
    errors        = 0;
    burst_left    = 0;
    chars_sent    = 0;
    hold_req      = 1'b0;
    typed_pending = 1'b0;
    radix_reg     = RADIX_RESET;
    clear_number();

    dir_rows[0] = '{RADIX_DEC,   4'd2, "7;",        1'b1, 64'd7, 8'd1};
    dir_rows[1] = '{RADIX_AUTO,  4'd7, "\t-0x1f ",  1'b1, 64'hFFFF_FFFF_FFFF_FFE1, 8'd6};
    dir_rows[2] = '{RADIX_HEX,   4'd3, "0xg",       1'b1, 64'd0, 8'd2};
    dir_rows[3] = '{RADIX_AUTO,  4'd2, "+-",        1'b1, 64'd0, 8'd1};
    dir_rows[4] = '{RADIX_AUTO,  4'd4, "0178",      1'b1, 64'd15, 8'd3};
    dir_rows[5] = '{RADIX_ALNUM, 4'd3, {"zZ", 8'hFF}, 1'b0, 64'd0, 8'd0};
    dir_rows[6] = '{RADIX_UNARY, 4'd3, "00a",       1'b1, 64'd0, 8'd2};
    dir_rows[7] = '{RADIX_TOP,   4'd2, {"z", 8'h00}, 1'b1, 64'd35, 8'd1};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first row runs on the radix left by reset.
    for (r = 0; r < NUM_ROWS; r++) begin
      row = dir_rows[r];
      if (r != 0) set_radix(row.radix);
      typed_pending = row.known;
      typed_number  = '{row.value, row.consumed};
      for (i = 0; i < row.len; i++) begin
        c = row.txt[8 * (row.len - 1 - i) +: 8];
        send_char(c);
      end
    end

    chars_sent = 0;
    phase_no   = 0;
    while (chars_sent < RANDOM_CHARS) begin
      case (phase_no % 10)
        0: rad = RADIX_AUTO;
        1: rad = RADIX_HEX;
        2: rad = RADIX_DEC;
        3: rad = RADIX_OCT;
        4: rad = RADIX_BIN;
        5: rad = RADIX_ALNUM;
        6: rad = RADIX_UNARY;
        7: rad = RADIX_TOP;
        8: rad = RADIX_ODD;
        default: rad = RADIX_W'($urandom);
      endcase
      set_radix(rad);
      // Long output stall while the input keeps coming, so the block backs up.
      if (phase_no == 3) hold_req = 1'b1;
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) gen_number(rad);
      // Leaves the parser in the whitespace phase before the next register write.
      send_char(CH_FLUSH);
      phase_no++;
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- radix_integer_text_parser_core.f -----
design/rtip_pkg.sv
design/rtip_step.sv
design/radix_integer_text_parser_core.sv
tb/sv/tb_radix_integer_text_parser_core.sv
